/* src/rgbna_pkg.sv */
// rgbna_pkg: types, constants and the palette table for the nearest
// 256-color palette index search. No dependencies.
`timescale 1ns / 1ps

package rgbna_pkg;

    // one palette color, red in the lowest byte
    typedef logic [23:0] rgb_t;
    typedef rgb_t pal_rom_t [256];

    // squared distance, max 3*255*255 fits in 18 bits
    typedef logic [17:0] dist_t;

    localparam int unsigned PalDepth  = 256;
    localparam int unsigned SysCount  = 16;
    localparam int unsigned CubeLast  = 231;
    localparam int unsigned GreyFirst = 232;
    localparam int unsigned CubeSide  = 6;
    localparam int unsigned CubePlane = 36;
    localparam int unsigned GreyBase  = 8;
    localparam int unsigned GreyStep  = 10;

    localparam logic [7:0] LAST_INDEX = 8'(PalDepth - 1);

    // system colors, each {blue, green, red}
    localparam rgb_t SYS_COLORS [SysCount] = '{
        24'h000000, 24'h000080, 24'h008000, 24'h008080,
        24'h800000, 24'h800080, 24'h808000, 24'hC0C0C0,
        24'h808080, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
        24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
    };

    localparam logic [7:0] CUBE_LEVELS [CubeSide] = '{
        8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
    };

    // one palette entry by index
    function automatic rgb_t palette_entry(input int unsigned idx);
        int unsigned n;
        logic [7:0]  grey;
        rgb_t        c;
        n    = 0;
        grey = '0;
        if (idx < SysCount) begin
            c = SYS_COLORS[idx[3:0]];
        end else if (idx <= CubeLast) begin
            n = idx - SysCount;
            c = {CUBE_LEVELS[3'(n % CubeSide)],
                 CUBE_LEVELS[3'((n / CubeSide) % CubeSide)],
                 CUBE_LEVELS[3'((n / CubePlane) % CubeSide)]};
        end else begin
            grey = 8'(GreyBase + (idx - GreyFirst) * GreyStep);
            c    = {grey, grey, grey};
        end
        return c;
    endfunction

    // whole palette, evaluated at elaboration
    function automatic pal_rom_t build_palette();
        pal_rom_t rom;
        for (int unsigned i = 0; i < PalDepth; i++) begin
            rom[8'(i)] = palette_entry(i);
        end
        return rom;
    endfunction

endpackage

/* src/rgb_nearest_ansi256_index.sv */
// rgb_nearest_ansi256_index: nearest 256-color palette index for an rgb beat.
// Depends on rgbna_pkg for the palette table and distance types.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one beat carries a 24-bit color (red, green, blue). The block
//   takes a beat only while it is idle, one color at a time.
//   m_ channel: one beat per color carries the 8-bit palette index at the
//   smallest squared distance, the lowest index on a tie.
//   Search: from the accepting edge to m_tvalid, the palette ROM is read once
//   per entry, 256 reads in a row, followed by two pipeline stages (squares,
//   then sum and compare), and then the output register is loaded.
//   Throughput: one color at a time; a new one is taken only once the last
//   result is loaded. The palette ROM read port and the single distance unit set that limit.
//   Stall: the result waits in the output register; the next color can be
//   accepted and searched meanwhile, and its result is held back until the
//   output register is free.
//   Reset: aresetn low clears the control state and drops m_tvalid; the
//   palette is a constant ROM and needs no fill.
module rgb_nearest_ansi256_index
    import rgbna_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // palette_index [7:0]
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

    localparam pal_rom_t PAL_ROM = build_palette();

    state_t      state_reg;
    rgb_t        color_reg;
    logic [7:0]  addr_reg;
    rgb_t        rom_q_reg;
    logic        v1_reg;
    logic [7:0]  idx1_reg;
    logic [15:0] sq_r_reg, sq_g_reg, sq_b_reg;
    logic        v2_reg;
    logic [7:0]  idx2_reg;
    dist_t       near_dist_reg;
    logic [7:0]  near_idx_reg;
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;

    logic [7:0]  diff_r, diff_g, diff_b;
    dist_t       dist_sum;
    logic        take;
    logic        out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // absolute channel differences against the palette entry
    always_comb begin
        diff_r = (color_reg[7:0] > rom_q_reg[7:0]) ? color_reg[7:0] - rom_q_reg[7:0]
                                                   : rom_q_reg[7:0] - color_reg[7:0];
        diff_g = (color_reg[15:8] > rom_q_reg[15:8]) ? color_reg[15:8] - rom_q_reg[15:8]
                                                     : rom_q_reg[15:8] - color_reg[15:8];
        diff_b = (color_reg[23:16] > rom_q_reg[23:16])
                 ? color_reg[23:16] - rom_q_reg[23:16]
                 : rom_q_reg[23:16] - color_reg[23:16];
    end

    // distance sum and strict-less compare, first entry always taken
    always_comb begin
        dist_sum = 18'(sq_r_reg) + 18'(sq_g_reg) + 18'(sq_b_reg);
        take     = (idx2_reg == 8'd0) || (dist_sum < near_dist_reg);
    end

    // palette rom read, one entry per cycle
    always_ff @(posedge aclk) begin
        rom_q_reg <= PAL_ROM[addr_reg];
        idx1_reg  <= addr_reg;
    end

    // squares stage
    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            sq_r_reg <= 16'(diff_r) * 16'(diff_r);
            sq_g_reg <= 16'(diff_g) * 16'(diff_g);
            sq_b_reg <= 16'(diff_b) * 16'(diff_b);
            idx2_reg <= idx1_reg;
        end
    end

    // best-so-far update
    always_ff @(posedge aclk) begin
        if (v2_reg && take) begin
            near_dist_reg <= dist_sum;
            near_idx_reg  <= idx2_reg;
        end
    end

    // sequencer, pipeline valids and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == ST_RUN);
            v2_reg <= v1_reg;
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        color_reg <= s_tdata;
                        addr_reg  <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    addr_reg <= addr_reg + 8'd1;
                    if (addr_reg == LAST_INDEX) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (v2_reg && idx2_reg == LAST_INDEX) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= near_idx_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // an accepted color starts the rom sweep
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_RUN && addr_reg == 8'd0)
        else $error("accepted beat did not start the palette sweep");

    // every rom read reaches the compare stage
    a_pipe_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |=> v2_reg && idx2_reg == $past(idx1_reg))
        else $error("rom read lost between pipeline stages");

    // last compare ends the search
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && idx2_reg == LAST_INDEX |=> state_reg == ST_DONE)
        else $error("search did not finish after the last palette entry");

    // pipeline is empty when the result is handed over
    a_done_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> !v1_reg && !v2_reg)
        else $error("result loaded with compares still in flight");

endmodule

/* verif/testbench.sv */
// testbench: self-checking bench for rgb_nearest_ansi256_index, nearest
// 256-color palette index search over squared distance. Needs only
// rgb_nearest_ansi256_index and rgbna_pkg; carries its own palette and search.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int unsigned DRAIN_CYCLES  = 300;
    localparam int unsigned HOLD_OFF_LEN  = 1500;
    localparam int unsigned RANDOM_COLORS = 1330;

    // palette as {red, green, blue}, red in the top byte
    localparam logic [23:0] SYSTEM_RGB [16] = '{
        24'h000000, 24'h800000, 24'h008000, 24'h808000,
        24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
        24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
        24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
    };
    localparam logic [7:0] CUBE_STEPS [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] index;
    } color_job_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // red [7:0], green [15:8], blue [23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // palette_index [7:0]

    color_job_t  awaited_index [$];
    color_job_t  head_job;

    int unsigned colors_sent      = 0;
    int unsigned indices_checked  = 0;
    int unsigned mismatch_count   = 0;
    int unsigned input_stalls     = 0;
    int unsigned cycle_count      = 0;
    int unsigned hold_off_request = 0;
    int unsigned rx_stall_left    = 0;
    bit          tx_gaps          = 1'b1;
    bit          rx_random        = 1'b1;

    rgb_nearest_ansi256_index dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock, 12 ns period
    initial begin
        forever #6 aclk = ~aclk;
    end

    // palette entry by index
    function automatic logic [23:0] xterm_color(input int unsigned idx);
        int unsigned n;
        logic [7:0]  grey;
        if (idx < 16) begin
            return SYSTEM_RGB[4'(idx)];
        end else if (idx < 232) begin
            n = idx - 16;
            return {CUBE_STEPS[3'(n / 36)], CUBE_STEPS[3'((n / 6) % 6)],
                    CUBE_STEPS[3'(n % 6)]};
        end
        grey = 8'(8 + (idx - 232) * 10);
        return {grey, grey, grey};
    endfunction

    // exhaustive search, strictly nearer replaces so the lowest index wins ties
    function automatic logic [7:0] nearest_palette_index(input logic [7:0] r, g, b);
        logic [23:0] c;
        logic [7:0]  dr, dg, db;
        logic [17:0] cand_dist;
        logic [18:0] near_dist;
        logic [7:0]  near_index;
        near_dist  = '1;
        near_index = '0;
        for (int unsigned i = 0; i < 256; i++) begin
            c    = xterm_color(i);
            dr   = (r > c[23:16]) ? r - c[23:16] : c[23:16] - r;
            dg   = (g > c[15:8])  ? g - c[15:8]  : c[15:8]  - g;
            db   = (b > c[7:0])   ? b - c[7:0]   : c[7:0]   - b;
            cand_dist = 18'(dr) * 18'(dr) + 18'(dg) * 18'(dg) + 18'(db) * 18'(db);
            if ({1'b0, cand_dist} < near_dist) begin
                near_dist  = {1'b0, cand_dist};
                near_index = 8'(i);
            end
        end
        return near_index;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // value moved by up to +-span, clamped to a byte
    function automatic logic [7:0] jitter(input logic [7:0] v, input int unsigned span);
        int t;
        t = int'(v) + int'($urandom_range(0, 2 * span)) - int'(span);
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return 8'(t);
    endfunction

    // drop valid for a random stretch, junk on the data lines
    task automatic sender_gap();
        int unsigned n;
        n = pick_gap_length();
        if (n > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // offer one color beat and record its expected index once accepted
    task automatic send_color(input logic [7:0] r, g, b);
        color_job_t job;
        job.red   = r;
        job.green = g;
        job.blue  = b;
        job.index = nearest_palette_index(r, g, b);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        awaited_index.push_back(job);
        colors_sent++;
        if (tx_gaps) begin
            sender_gap();
        end
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // sender pause until every outstanding index has come back
    task automatic wait_for_results();
        release_input();
        while (awaited_index.size() != 0) @(posedge aclk);
    endtask

    // exact palette colors, tie points and extremes
    task automatic test_directed_colors();
        logic [23:0] colors [22];
        colors = '{
            24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h800000,
            24'h008000, 24'h000080, 24'hC0C0C0, 24'h808080, 24'h080808, 24'hEEEEEE,
            24'h5F87AF, 24'h2F0000, 24'h300000, 24'h7F7F7F, 24'h818181, 24'hC1C1C1,
            24'h010203, 24'hFEFDFC, 24'h5A5A5A, 24'hAA55AA
        };
        tx_gaps   = 1'b1;
        rx_random = 1'b1;
        foreach (colors[i]) begin
            send_color(colors[i][23:16], colors[i][15:8], colors[i][7:0]);
        end
        wait_for_results();
    endtask

    // back to back on both sides, no idling at all
    task automatic test_back_to_back();
        tx_gaps   = 1'b0;
        rx_random = 1'b0;
        for (int i = 0; i < 40; i++) begin
            send_color(8'($urandom), 8'($urandom), 8'($urandom));
        end
        wait_for_results();
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_output_hold_off();
        tx_gaps          = 1'b0;
        rx_random        = 1'b1;
        hold_off_request = HOLD_OFF_LEN;
        for (int i = 0; i < 6; i++) begin
            send_color(8'($urandom), 8'($urandom), 8'($urandom));
        end
        wait_for_results();
    endtask

    // random colors: uniform, near palette entries and near greys
    task automatic test_random_colors(input int unsigned count);
        logic [23:0] c;
        logic [7:0]  v;
        int unsigned kind;
        for (int unsigned i = 0; i < count; i++) begin
            // change idling modes now and then, pause for a full drain sometimes
            if (i % 250 == 0) begin
                tx_gaps   = ($urandom_range(0, 3) != 0);
                rx_random = ($urandom_range(0, 3) != 0);
            end
            if (i % 300 == 299) begin
                wait_for_results();
            end
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                c = 24'($urandom);
                send_color(c[23:16], c[15:8], c[7:0]);
            end else if (kind < 8) begin
                c = xterm_color($urandom_range(0, 255));
                send_color(jitter(c[23:16], 3), jitter(c[15:8], 3), jitter(c[7:0], 3));
            end else begin
                v = 8'($urandom);
                send_color(jitter(v, 2), jitter(v, 2), jitter(v, 2));
            end
        end
        wait_for_results();
    endtask

    // result sink: random stalls plus the requested long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_stall_left > 0) begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end else if (hold_off_request > 0) begin
                m_tready <= 1'b0;
                rx_stall_left    = hold_off_request - 1;
                hold_off_request = 0;
            end else if (rx_random && $urandom_range(0, 99) < 25) begin
                m_tready <= 1'b0;
                rx_stall_left = ($urandom_range(0, 99) < 94) ? $urandom_range(0, 3)
                                                              : $urandom_range(20, 300);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each index beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && !s_tready) begin
            input_stalls++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_index.size() == 0) begin
                $display("%0t ns: unexpected palette index beat, actual %0d", $time, m_tdata);
                mismatch_count++;
            end else begin
                head_job = awaited_index.pop_front();
                indices_checked++;
                if (m_tdata !== head_job.index) begin
                    $display("%0t ns: rgb %02h %02h %02h, expected index %0d, actual %0d",
                             $time, head_job.red, head_job.green, head_job.blue,
                             head_job.index, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t ns: timeout, %0d indices still awaited", $time, awaited_index.size());
        $display("FAILURE");
        $finish;
    end

    // test sequence
    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_colors();
        test_back_to_back();
        test_output_hold_off();
        test_random_colors(RANDOM_COLORS);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d colors: tie points, system/cube/grey entries, random mix",
                 colors_sent);
        $display("%0d indices checked, %0d input stall cycles, %0d mismatches",
                 indices_checked, input_stalls, mismatch_count);
        if (mismatch_count == 0 && awaited_index.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
